// ===== rtl/mbrt_pkg.sv =====
package mbrt_pkg;

    localparam int MAX_BLOCKS_DEF  = 64;
    localparam int BLOCK_BYTES_DEF = 512;

    // Field widths.
    localparam int MODE_W   = 3;
    localparam int BLK_W    = 6;
    localparam int CNT_W    = 10;
    localparam int NUMB_W   = 7;
    localparam int DELAY_W  = 16;
    localparam int RETRY_W  = 8;
    localparam int BYTES_W  = 16;
    localparam int CUR_W    = 7;
    // Wide enough for the effective block count (up to 127).
    localparam int N_W      = 9;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd2;

    localparam logic [NUMB_W-1:0]  NUM_BLOCKS_RST  = 7'd64;
    localparam logic [DELAY_W-1:0] RETRY_DELAY_RST = 16'd60;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd10;

    // Command codes.
    localparam logic [MODE_W-1:0] MODE_START = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RECV  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SETC  = 3'd4;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fix;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_fix;
    } t_dp_stat;

endpackage

// ===== rtl/mbrt_in_if.sv =====
interface mbrt_in_if;
    logic                         valid;
    logic                         ready;
    logic [mbrt_pkg::MODE_W-1:0]  mode;
    logic [mbrt_pkg::BLK_W-1:0]   block;
    logic [mbrt_pkg::CNT_W-1:0]   byte_count;
    logic                         complete_value;

    modport source (output valid, mode, block, byte_count, complete_value, input ready);
    modport sink   (input valid, mode, block, byte_count, complete_value, output ready);
endinterface

// ===== rtl/mbrt_out_if.sv =====
interface mbrt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          wait_done;
    logic [mbrt_pkg::BLK_W-1:0]    next_block;
    logic                          ready_res;
    logic                          complete;
    logic [mbrt_pkg::BYTES_W-1:0]  total_bytes;
    logic [mbrt_pkg::RETRY_W-1:0]  retries;

    modport source (output valid, wait_done, next_block, ready_res, complete, total_bytes,
                    retries, input ready);
    modport sink   (input valid, wait_done, next_block, ready_res, complete, total_bytes,
                    retries, output ready);
endinterface

// ===== rtl/mbrt_ctrl.sv =====
module mbrt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  mbrt_pkg::t_dp_stat i_stat,
    output mbrt_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIX,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign load        = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.capture  = i_in_valid && o_in_ready;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.fix      = (r_state == S_FIX);
    assign o_cmd.load_out = load;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.need_fix ? S_FIX : S_OUT;
            end
            S_FIX: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A new result replaces one taken in the same cycle.
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/mbrt_dp.sv =====
module mbrt_dp #(
    parameter int MAX_BLOCKS  = mbrt_pkg::MAX_BLOCKS_DEF,
    parameter int BLOCK_BYTES = mbrt_pkg::BLOCK_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mbrt_pkg::t_dp_cmd                   i_cmd,
    output mbrt_pkg::t_dp_stat                  o_stat,
    input  logic                                i_cfg_we,
    input  logic [mbrt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mbrt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [mbrt_pkg::MODE_W-1:0]         i_mode,
    input  logic [mbrt_pkg::BLK_W-1:0]          i_block,
    input  logic [mbrt_pkg::CNT_W-1:0]          i_byte_count,
    input  logic                                i_complete_value,
    output logic                                o_wait_done,
    output logic [mbrt_pkg::BLK_W-1:0]          o_next_block,
    output logic                                o_ready_res,
    output logic                                o_complete,
    output logic [mbrt_pkg::BYTES_W-1:0]        o_total_bytes,
    output logic [mbrt_pkg::RETRY_W-1:0]        o_retries
);

    localparam int N_W     = mbrt_pkg::N_W;
    localparam int CUR_W   = mbrt_pkg::CUR_W;
    localparam int BYTES_W = mbrt_pkg::BYTES_W;
    localparam int RETRY_W = mbrt_pkg::RETRY_W;
    localparam int DELAY_W = mbrt_pkg::DELAY_W;
    localparam logic [N_W-1:0]     MAX_N   = N_W'(MAX_BLOCKS);
    localparam logic [BYTES_W-1:0] CNT_CAP = BYTES_W'(BLOCK_BYTES);

    // Configuration.
    logic [mbrt_pkg::NUMB_W-1:0]  r_num_blocks;
    logic [DELAY_W-1:0]           r_retry_delay;
    logic [RETRY_W-1:0]           r_retry_limit;

    // Tracker state.
    logic [MAX_BLOCKS-1:0]        r_map;
    logic [CUR_W-1:0]             r_cursor;
    logic [DELAY_W-1:0]           r_delay;
    logic [RETRY_W-1:0]           r_retry;
    logic [BYTES_W-1:0]           r_bytes;
    logic                         r_ready;
    logic                         r_complete;
    logic                         r_wait;
    logic [mbrt_pkg::BLK_W-1:0]   r_next;
    logic                         r_hit1;

    // Captured command.
    logic [mbrt_pkg::MODE_W-1:0]  r_mode;
    logic [mbrt_pkg::BLK_W-1:0]   r_blk;
    logic [mbrt_pkg::CNT_W-1:0]   r_cnt;
    logic                         r_cval;

    // Result register.
    logic                         r_o_wait;
    logic [mbrt_pkg::BLK_W-1:0]   r_o_next;
    logic                         r_o_ready;
    logic                         r_o_complete;
    logic [BYTES_W-1:0]           r_o_bytes;
    logic [RETRY_W-1:0]           r_o_retry;

    logic [N_W-1:0]        n_eff;
    logic [CUR_W-1:0]      start;
    logic [MAX_BLOCKS-1:0] in_range;
    logic [MAX_BLOCKS-1:0] cand;
    logic [MAX_BLOCKS-1:0] lowest;
    logic [MAX_BLOCKS-1:0] sel;
    logic [CUR_W-1:0]      found_idx;
    logic                  found;
    logic                  new_blk;
    logic                  last_hit;
    logic [BYTES_W-1:0]    cnt_sat;
    logic [BYTES_W:0]      byte_sum;
    logic [RETRY_W-1:0]    retry_inc;

    assign n_eff = ({2'b00, r_num_blocks} > MAX_N) ? MAX_N : {2'b00, r_num_blocks};
    assign start = i_cmd.fix ? '0 : r_cursor;

    // Shared first-missing search: isolate the lowest candidate bit, then encode it.
    always_comb begin
        for (int j = 0; j < MAX_BLOCKS; j++) begin
            in_range[j] = (N_W'(j) < n_eff);
            cand[j]     = !r_map[j] && in_range[j] && (N_W'(j) >= {2'b00, start});
            sel[j]      = (N_W'(j) == {3'b000, r_blk});
        end
        lowest    = cand & (~cand + MAX_BLOCKS'(1));
        found_idx = '0;
        for (int j = 0; j < MAX_BLOCKS; j++) begin
            if (lowest[j]) begin
                found_idx = found_idx | CUR_W'(j);
            end
        end
    end

    assign found    = |cand;
    assign new_blk  = |(sel & in_range & ~r_map);
    assign last_hit = (N_W'(found_idx) + N_W'(1)) >= n_eff;

    always_comb begin
        case (r_mode)
            mbrt_pkg::MODE_NEXT: o_stat.need_fix = !found || last_hit;
            mbrt_pkg::MODE_RECV: o_stat.need_fix = new_blk;
            default:             o_stat.need_fix = 1'b0;
        endcase
    end

    assign cnt_sat   = ({6'd0, r_cnt} > CNT_CAP) ? CNT_CAP : {6'd0, r_cnt};
    assign byte_sum  = {1'b0, r_bytes} + {1'b0, cnt_sat};
    assign retry_inc = (r_retry == '1) ? r_retry : r_retry + RETRY_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_blocks  <= mbrt_pkg::NUM_BLOCKS_RST;
            r_retry_delay <= mbrt_pkg::RETRY_DELAY_RST;
            r_retry_limit <= mbrt_pkg::RETRY_LIMIT_RST;
            r_map         <= '0;
            r_cursor      <= '0;
            r_delay       <= '0;
            r_retry       <= '0;
            r_bytes       <= '0;
            r_ready       <= 1'b1;
            r_complete    <= 1'b0;
            r_wait        <= 1'b0;
            r_next        <= '0;
            r_hit1        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mbrt_pkg::CFG_NUM_BLOCKS:  r_num_blocks  <= i_cfg_wdata[mbrt_pkg::NUMB_W-1:0];
                    mbrt_pkg::CFG_RETRY_DELAY: r_retry_delay <= i_cfg_wdata;
                    mbrt_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata[RETRY_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.exec) begin
                r_wait <= 1'b0;
                r_next <= '0;
                r_hit1 <= 1'b0;
                case (r_mode)
                    mbrt_pkg::MODE_START: begin
                        r_map      <= '0;
                        r_cursor   <= '0;
                        r_delay    <= '0;
                        r_retry    <= '0;
                        r_bytes    <= '0;
                        r_ready    <= 1'b0;
                        r_complete <= 1'b0;
                    end
                    mbrt_pkg::MODE_TICK: begin
                        if (r_delay != '0) begin
                            r_delay <= r_delay - DELAY_W'(1);
                        end else begin
                            r_wait <= 1'b1;
                        end
                    end
                    mbrt_pkg::MODE_NEXT: begin
                        if (found) begin
                            r_cursor <= found_idx + CUR_W'(1);
                            r_next   <= found_idx[mbrt_pkg::BLK_W-1:0];
                            r_hit1   <= 1'b1;
                        end
                    end
                    mbrt_pkg::MODE_RECV: begin
                        if (new_blk) begin
                            r_map   <= r_map | sel;
                            r_bytes <= byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
                        end
                    end
                    mbrt_pkg::MODE_SETC: begin
                        r_complete <= r_cval;
                    end
                    default: ;
                endcase
            end

            // Second pass, searching from block zero: a rewind, or the all-present check.
            if (i_cmd.fix) begin
                if (r_mode == mbrt_pkg::MODE_NEXT) begin
                    if (found) begin
                        r_cursor <= found_idx;
                        r_delay  <= r_retry_delay;
                        r_retry  <= retry_inc;
                        if (r_retry >= r_retry_limit) begin
                            r_ready <= 1'b1;
                        end
                    end
                    if (!r_hit1) begin
                        r_next <= found ? found_idx[mbrt_pkg::BLK_W-1:0]
                                        : r_cursor[mbrt_pkg::BLK_W-1:0];
                    end
                end else if (!found) begin
                    r_ready    <= 1'b1;
                    r_complete <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_blk  <= i_block;
            r_cnt  <= i_byte_count;
            r_cval <= i_complete_value;
        end
        if (i_cmd.load_out) begin
            r_o_wait     <= r_wait;
            r_o_next     <= r_next;
            r_o_ready    <= r_ready;
            r_o_complete <= r_complete;
            r_o_bytes    <= r_bytes;
            r_o_retry    <= r_retry;
        end
    end

    assign o_wait_done   = r_o_wait;
    assign o_next_block  = r_o_next;
    assign o_ready_res   = r_o_ready;
    assign o_complete    = r_o_complete;
    assign o_total_bytes = r_o_bytes;
    assign o_retries     = r_o_retry;

endmodule

// ===== rtl/missing_block_retry_tracker.sv =====
// Receive-side tracker for a transfer split into numbered blocks.
// Commands arrive on the input channel (start, tick, next request, block
// received, set complete); every command gives exactly one result transfer
// with the tick and next-request values and the status after the command.
// Both channels use valid/ready; a transfer happens when both are high.
// Configuration (block count, retry delay, retry limit) is written through
// the plain write port; the user must do so only while no command is in
// flight, as the block itself does not enforce it.
// Steps: a command is accepted in the idle state, runs in the execute
// state and is loaded into the result register in the output state; only
// then does the block return to idle and take the next command.
// A next request that rewinds, and a received block that is new, also pass
// the fix state after execute, where the single first-missing search unit
// makes a second pass over the received bitmap from block zero.
// The result register frees the input side: a new command is accepted
// while an earlier result still waits; if the receiver stalls, the
// following command holds in its final step until the result is taken.
// Reset clears the bitmap and counters, sets the ready flag and loads the
// default configuration; the block accepts a command in the next cycle.
module missing_block_retry_tracker #(
    parameter int MAX_BLOCKS  = mbrt_pkg::MAX_BLOCKS_DEF,
    parameter int BLOCK_BYTES = mbrt_pkg::BLOCK_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mbrt_in_if.sink                         i_in,
    mbrt_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [mbrt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbrt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    mbrt_pkg::t_dp_cmd  cmd;
    mbrt_pkg::t_dp_stat stat;

    mbrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mbrt_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_mode           (i_in.mode),
        .i_block          (i_in.block),
        .i_byte_count     (i_in.byte_count),
        .i_complete_value (i_in.complete_value),
        .o_wait_done      (o_out.wait_done),
        .o_next_block     (o_out.next_block),
        .o_ready_res      (o_out.ready_res),
        .o_complete       (o_out.complete),
        .o_total_bytes    (o_out.total_bytes),
        .o_retries        (o_out.retries)
    );

endmodule
